FILE: rtl/core/ptb_pkg.sv
// types and constants for the paced transfer token bucket
`timescale 1ns / 1ps
`default_nettype none

package ptb_pkg;

	localparam int CFG_W = 32;
	localparam int CHUNK_W = 25;
	localparam int SPAN_W = 32;
	localparam int RATE_W = 32;
	localparam int TOK_W = 33;
	localparam int TIME_W = 63;
	localparam int LEN_W = 32;
	localparam int WAIT_W = 48;
	localparam int DIV_W = 64;
	localparam int DCNT_W = 6;

	localparam logic [31:0] NS_PER_SEC = 32'd1000000000;
	localparam logic [31:0] MAX_ELAPSED = 32'd2000000000;
	localparam logic [CHUNK_W-1:0] CHUNK_LIMIT_RST = 25'd1048576;
	localparam logic [CHUNK_W-1:0] BURST_FLOOR_RST = 25'd65536;
	localparam logic [SPAN_W-1:0] PREFETCH_SPAN_RST = 32'd268435456;
	localparam logic [SPAN_W-1:0] SPAN_MIN = 32'd4;

	typedef enum logic [1:0] {
		CFG_CHUNK_LIMIT = 2'd0,
		CFG_BURST_FLOOR = 2'd1,
		CFG_PREFETCH_SPAN = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_DONE = 2'd1,
		CMD_WAKE = 2'd2,
		CMD_ERROR = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		K_SEND = 3'd0,
		K_WAIT = 3'd1,
		K_HINT = 3'd2,
		K_FINISH = 3'd3,
		K_CANCEL = 3'd4,
		K_REJECT = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_BUSY = 2'd1,
		PH_WAIT = 2'd2
	} phase_t;

	typedef enum logic [11:0] {
		ST_IDLE = 12'b000000000001,
		ST_DECODE = 12'b000000000010,
		ST_SHINT = 12'b000000000100,
		ST_CHK = 12'b000000001000,
		ST_PHINT = 12'b000000010000,
		ST_REQ = 12'b000000100000,
		ST_MUL = 12'b000001000000,
		ST_DIV = 12'b000010000000,
		ST_REFILL = 12'b000100000000,
		ST_DECIDE = 12'b001000000000,
		ST_WOUT = 12'b010000000000,
		ST_MARK = 12'b100000000000
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/core/paced_transfer_token_bucket.sv
// paced byte-range transfer with a token bucket, sequenced over a shared multiplier and divider
//
// usage: one command beat enters on in_valid/in_stall (start session, chunk done,
// wait expired, error). each command yields one or two result beats on
// out_valid/out_stall: an optional prefetch hint, then a send chunk, a wait time,
// or a finished/cancel/rejected mark; last marks the final beat of a command.
// config registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while idle, as the block itself does not enforce it.
// a paced send runs one multiply and a 64-step restoring divide for the token
// refill; a wait adds a second multiply and divide. the divider is serial,
// one quotient bit per cycle; marks and unpaced sends use neither unit.
// in_stall is low only while the sequencer is idle; one command at a time.
// results leave through an output register, so the next command is taken
// while the last result still waits. a stalled receiver holds the sequencer
// at its next result until the output register frees.
// reset clears the session (idle, no tokens) and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module paced_transfer_token_bucket
	import ptb_pkg::*;
#(
	parameter int OFFSET_BITS = 48
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [CFG_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] cmd,
	input wire logic [TIME_W-1:0] now_ns,
	input wire logic [OFFSET_BITS-1:0] range_start,
	input wire logic [OFFSET_BITS-1:0] range_end,
	input wire logic [RATE_W-1:0] byte_rate,
	input wire logic [CHUNK_W-1:0] bytes_done,
	output logic out_valid,
	input wire logic out_stall,
	output logic [2:0] kind,
	output logic [OFFSET_BITS-1:0] offset,
	output logic [LEN_W-1:0] length,
	output logic [WAIT_W-1:0] wait_ns,
	output logic last
);

	localparam int OB = OFFSET_BITS;

	state_t state_q;
	phase_t phase_q;
	kind_t mark_q;

	logic [CHUNK_W-1:0] chunk_limit_q;
	logic [CHUNK_W-1:0] burst_floor_q;
	logic [SPAN_W-1:0] prefetch_span_q;

	logic [OB-1:0] start_offset_q;
	logic [OB-1:0] end_offset_q;
	logic [OB-1:0] total_q;
	logic [OB-1:0] sent_q;
	logic [OB-1:0] prefetch_next_q;
	logic [TOK_W-1:0] token_q;
	logic [TIME_W-1:0] last_time_q;
	logic [RATE_W-1:0] rate_q;

	cmd_t cmd_q;
	logic [TIME_W-1:0] now_q;
	logic [OB-1:0] rs_q;
	logic [OB-1:0] re_q;
	logic [RATE_W-1:0] br_q;
	logic [CHUNK_W-1:0] done_q;

	logic [31:0] opa_q;
	logic [31:0] opb_q;
	logic [31:0] div_q;
	logic [DIV_W-1:0] dvd_q;
	logic [31:0] rem_q;
	logic [DCNT_W-1:0] cnt_q;
	logic pass_q;

	logic out_valid_q;
	kind_t kind_q;
	logic [OB-1:0] offset_q;
	logic [LEN_W-1:0] length_q;
	logic [WAIT_W-1:0] wait_ns_q;
	logic last_q;

	logic slot_free;
	logic emit_en;
	logic emit_go;
	kind_t emit_kind;
	logic [OB-1:0] emit_off;
	logic [LEN_W-1:0] emit_len;
	logic [WAIT_W-1:0] emit_wait;
	logic emit_last;

	logic [CHUNK_W-1:0] cl_used;
	logic [CHUNK_W-1:0] floor_used;
	logic [SPAN_W-1:0] span_used;
	logic [OB-1:0] s_end;
	logic [OB:0] s_pf_sum;
	logic [OB-1:0] s_pf;
	logic [OB-1:0] done_ext;
	logic [OB-1:0] remaining;
	logic [OB-1:0] cur_off;
	logic [OB-1:0] hint_thr;
	logic hint_cond;
	logic [OB:0] pf_sum;
	logic [OB-1:0] pf_sat;
	logic more;
	logic [TIME_W-1:0] dlt_raw;
	logic [31:0] dlt;
	logic [TOK_W-1:0] max_tok;
	logic [CHUNK_W-1:0] c1;
	logic [TOK_W-1:0] c2;
	logic [TOK_W-1:0] c3;
	logic [CHUNK_W-1:0] mb1;
	logic [TOK_W-1:0] min_burst;
	logic [TOK_W-1:0] short_by;
	logic short_tok;
	logic [TOK_W+1:0] tok_sum;
	logic [DIV_W-1:0] mul_p;
	logic [32:0] div_trial;
	logic [32:0] div_diff;
	logic div_ge;

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign offset = offset_q;
	assign length = length_q;
	assign wait_ns = wait_ns_q;
	assign last = last_q;

	// register clamps
	assign cl_used = (chunk_limit_q == '0) ? CHUNK_W'(1) : chunk_limit_q;
	assign floor_used = (burst_floor_q == '0) ? CHUNK_W'(1) : burst_floor_q;
	assign span_used = (prefetch_span_q < SPAN_MIN) ? SPAN_MIN : prefetch_span_q;

	// session start
	assign s_end = (re_q > rs_q) ? re_q : rs_q;
	assign s_pf_sum = {1'b0, rs_q} + (OB+1)'(span_used);
	assign s_pf = s_pf_sum[OB] ? '1 : s_pf_sum[OB-1:0];

	// completion and prefetch watermark
	assign done_ext = OB'(done_q);
	assign remaining = total_q - sent_q;
	assign cur_off = start_offset_q + sent_q;
	assign hint_thr = prefetch_next_q - OB'(span_used >> 2);
	assign hint_cond = (cur_off >= hint_thr) && (prefetch_next_q < end_offset_q);
	assign pf_sum = {1'b0, prefetch_next_q} + (OB+1)'(span_used);
	assign pf_sat = pf_sum[OB] ? '1 : pf_sum[OB-1:0];
	assign more = (sent_q < total_q);

	// token bucket
	assign dlt_raw = (now_q >= last_time_q) ? (now_q - last_time_q) : '0;
	assign dlt = (dlt_raw > TIME_W'(MAX_ELAPSED)) ? MAX_ELAPSED : dlt_raw[31:0];
	assign max_tok = {rate_q, 1'b0};
	assign c1 = (remaining < OB'(cl_used)) ? remaining[CHUNK_W-1:0] : cl_used;
	assign c2 = (TOK_W'(c1) < max_tok) ? TOK_W'(c1) : max_tok;
	assign c3 = (c2 < token_q) ? c2 : token_q;
	assign mb1 = (remaining < OB'(floor_used)) ? remaining[CHUNK_W-1:0] : floor_used;
	assign min_burst = (TOK_W'(mb1) < max_tok) ? TOK_W'(mb1) : max_tok;
	assign short_tok = (token_q < min_burst);
	assign short_by = min_burst - token_q;
	assign tok_sum = (TOK_W+2)'(token_q) + (TOK_W+2)'(dvd_q[TOK_W:0]);

	// shared multiplier and restoring divider
	assign mul_p = opa_q * opb_q;
	assign div_trial = {rem_q, dvd_q[DIV_W-1]};
	assign div_ge = (div_trial >= {1'b0, div_q});
	assign div_diff = div_trial - {1'b0, div_q};

	assign slot_free = !out_valid_q || !out_stall;
	assign emit_go = emit_en && slot_free;

	always_comb begin
		emit_en = 1'b0;
		emit_kind = K_SEND;
		emit_off = '0;
		emit_len = '0;
		emit_wait = '0;
		emit_last = 1'b1;
		unique case (state_q)
			ST_SHINT: begin
				emit_en = 1'b1;
				emit_kind = K_HINT;
				emit_off = start_offset_q;
				emit_len = span_used;
				emit_last = 1'b0;
			end
			ST_PHINT: begin
				emit_en = 1'b1;
				emit_kind = K_HINT;
				emit_off = prefetch_next_q;
				emit_len = span_used;
				emit_last = 1'b0;
			end
			ST_REQ: begin
				emit_en = (rate_q == '0);
				emit_off = cur_off;
				emit_len = LEN_W'(c1);
			end
			ST_DECIDE: begin
				emit_en = !short_tok;
				emit_off = cur_off;
				emit_len = LEN_W'(c3[CHUNK_W-1:0]);
			end
			ST_WOUT: begin
				emit_en = 1'b1;
				emit_kind = K_WAIT;
				emit_wait = dvd_q[WAIT_W-1:0];
			end
			ST_MARK: begin
				emit_en = 1'b1;
				emit_kind = mark_q;
			end
			default: begin
				emit_en = 1'b0;
			end
		endcase
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_limit_q <= CHUNK_LIMIT_RST;
			burst_floor_q <= BURST_FLOOR_RST;
			prefetch_span_q <= PREFETCH_SPAN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CHUNK_LIMIT: chunk_limit_q <= cfg_data[CHUNK_W-1:0];
				CFG_BURST_FLOOR: burst_floor_q <= cfg_data[CHUNK_W-1:0];
				CFG_PREFETCH_SPAN: prefetch_span_q <= cfg_data[SPAN_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and session state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_IDLE;
			mark_q <= K_REJECT;
			start_offset_q <= '0;
			end_offset_q <= '0;
			total_q <= '0;
			sent_q <= '0;
			prefetch_next_q <= '0;
			token_q <= '0;
			last_time_q <= '0;
			rate_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					mark_q <= K_REJECT;
					state_q <= ST_MARK;
					unique case (cmd_q)
						CMD_START: begin
							if (phase_q == PH_IDLE) begin
								start_offset_q <= rs_q;
								end_offset_q <= s_end;
								total_q <= s_end - rs_q;
								sent_q <= '0;
								rate_q <= br_q;
								token_q <= {br_q, 1'b0};
								last_time_q <= now_q;
								prefetch_next_q <= s_pf;
								if (s_end == rs_q) begin
									mark_q <= K_FINISH;
								end else begin
									state_q <= ST_SHINT;
								end
							end
						end
						CMD_DONE: begin
							if (phase_q == PH_BUSY) begin
								sent_q <= sent_q + ((done_ext < remaining) ? done_ext : remaining);
								state_q <= ST_CHK;
							end
						end
						CMD_WAKE: begin
							if (phase_q == PH_WAIT) begin
								state_q <= ST_REQ;
							end
						end
						CMD_ERROR: begin
							if (phase_q != PH_IDLE) begin
								phase_q <= PH_IDLE;
								mark_q <= K_CANCEL;
							end
						end
						default: ;
					endcase
				end
				ST_SHINT: begin
					if (emit_go) begin
						state_q <= ST_REQ;
					end
				end
				ST_CHK, ST_PHINT: begin
					if (state_q == ST_CHK && hint_cond) begin
						state_q <= ST_PHINT;
					end else if (state_q == ST_CHK || emit_go) begin
						if (state_q == ST_PHINT) begin
							prefetch_next_q <= pf_sat;
						end
						if (more) begin
							state_q <= ST_REQ;
						end else begin
							phase_q <= PH_IDLE;
							mark_q <= K_FINISH;
							state_q <= ST_MARK;
						end
					end
				end
				ST_REQ: begin
					if (rate_q == '0) begin
						if (emit_go) begin
							phase_q <= PH_BUSY;
							state_q <= ST_IDLE;
						end
					end else begin
						last_time_q <= now_q;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= pass_q ? ST_WOUT : ST_REFILL;
					end
				end
				ST_REFILL: begin
					token_q <= (tok_sum > (TOK_W+2)'(max_tok)) ? max_tok : tok_sum[TOK_W-1:0];
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (short_tok) begin
						state_q <= ST_MUL;
					end else if (emit_go) begin
						token_q <= token_q - c3;
						phase_q <= PH_BUSY;
						state_q <= ST_IDLE;
					end
				end
				ST_WOUT: begin
					if (emit_go) begin
						phase_q <= PH_WAIT;
						state_q <= ST_IDLE;
					end
				end
				ST_MARK: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// command beat capture and arithmetic datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cmd_q <= cmd_t'(cmd);
			now_q <= now_ns;
			rs_q <= range_start;
			re_q <= range_end;
			br_q <= byte_rate;
			done_q <= bytes_done;
		end
		if (state_q == ST_REQ) begin
			opa_q <= dlt;
			opb_q <= rate_q;
			div_q <= NS_PER_SEC;
			pass_q <= 1'b0;
		end
		if (state_q == ST_DECIDE && short_tok) begin
			opa_q <= 32'(short_by[CHUNK_W-1:0]);
			opb_q <= NS_PER_SEC;
			div_q <= rate_q;
			pass_q <= 1'b1;
		end
		if (state_q == ST_MUL) begin
			dvd_q <= mul_p;
			rem_q <= '0;
			cnt_q <= '1;
		end
		if (state_q == ST_DIV) begin
			rem_q <= div_ge ? div_diff[31:0] : div_trial[31:0];
			dvd_q <= {dvd_q[DIV_W-2:0], div_ge};
			cnt_q <= cnt_q - DCNT_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			kind_q <= emit_kind;
			offset_q <= emit_off;
			length_q <= emit_len;
			wait_ns_q <= emit_wait;
			last_q <= emit_last;
		end
	end

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_DECODE))
		else $error("accepted command beat not decoded");

	a_tokens_capped: assert property (@(posedge clk) disable iff (!arst_n)
		token_q <= {rate_q, 1'b0})
		else $error("token count above bucket depth");

	a_sent_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		sent_q <= total_q)
		else $error("sent bytes beyond range length");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (div_q != '0))
		else $error("divide by zero in sequencer");

	a_emit_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(kind) && $stable(offset) && $stable(length))
		else $error("result overwritten while stalled");

endmodule

`default_nettype wire

FILE: bench/paced_transfer_token_bucket_tb.sv
// testbench for the paced transfer token bucket: directed and random command streams checked beat by beat
`timescale 1ns / 1ps

module paced_transfer_token_bucket_tb;
	import ptb_pkg::*;

	localparam int OFF_W = 48;
	localparam logic [63:0] OFF_MASK = (64'd1 << OFF_W) - 64'd1;
	localparam logic [63:0] SEC_NS = 64'd1_000_000_000;
	localparam logic [63:0] GAP_CAP_NS = 64'd2_000_000_000;
	localparam int unsigned DONE_MAX = 32'd16777216;
	localparam int QUIET_LIMIT = 10000;

	typedef struct {
		kind_t kind;
		logic [OFF_W-1:0] offset;
		logic [LEN_W-1:0] length;
		logic [WAIT_W-1:0] wait_ns;
		logic last;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] cmd = '0;
	logic [TIME_W-1:0] now_ns = '0;
	logic [OFF_W-1:0] range_start = '0;
	logic [OFF_W-1:0] range_end = '0;
	logic [RATE_W-1:0] byte_rate = '0;
	logic [CHUNK_W-1:0] bytes_done = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] kind;
	logic [OFF_W-1:0] offset;
	logic [LEN_W-1:0] length;
	logic [WAIT_W-1:0] wait_ns;
	logic last;

	// session and register copy
	logic [63:0] chunk_lim = 64'd1048576;
	logic [63:0] burst_flr = 64'd65536;
	logic [63:0] hint_span = 64'd268435456;
	phase_t sess_phase = PH_IDLE;
	logic [63:0] sess_start = '0;
	logic [63:0] sess_end = '0;
	logic [63:0] sess_total = '0;
	logic [63:0] sess_sent = '0;
	logic [63:0] hint_next = '0;
	logic [63:0] tokens = '0;
	logic [63:0] refill_ns = '0;
	logic [63:0] sess_rate = '0;
	logic [63:0] plan_len = '0;
	logic [63:0] plan_wait = '0;
	logic was_reject = 1'b0;

	beat_t pending_beats[$];
	beat_t want_beat;
	int err_cnt = 0;
	int beat_no = 0;
	int quiet = 0;
	int send_idle = 0;
	int recv_stall = 0;
	int hold_left = 0;
	int gap_left = 0;
	bit in_held = 1'b0;
	logic [63:0] clock_ns = '0;

	paced_transfer_token_bucket #(
		.OFFSET_BITS(OFF_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.now_ns(now_ns),
		.range_start(range_start),
		.range_end(range_end),
		.byte_rate(byte_rate),
		.bytes_done(bytes_done),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.offset(offset),
		.length(length),
		.wait_ns(wait_ns),
		.last(last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [63:0] min64(logic [63:0] a, logic [63:0] b);
		return (a < b) ? a : b;
	endfunction

	function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		return (s > OFF_MASK) ? OFF_MASK : s;
	endfunction

	function automatic logic [47:0] rand48();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[47:0];
	endfunction

	function automatic void add_beat(kind_t k, logic [63:0] off, logic [63:0] len,
			logic [63:0] w);
		beat_t b;
		b.kind = k;
		b.offset = off[OFF_W-1:0];
		b.length = len[LEN_W-1:0];
		b.wait_ns = w[WAIT_W-1:0];
		b.last = 1'b0;
		pending_beats.push_back(b);
	endfunction

	// refill the bucket if paced, then either a send chunk or a wait
	function automatic void plan_chunk(logic [63:0] t);
		logic [63:0] remaining, chunk, elapsed, cap, floor_u, min_burst;
		remaining = sess_total - sess_sent;
		chunk = min64(remaining, (chunk_lim == 0) ? 64'd1 : chunk_lim);
		if (sess_rate != 0) begin
			elapsed = (t >= refill_ns) ? t - refill_ns : 64'd0;
			cap = sess_rate * 64'd2;
			floor_u = (burst_flr == 0) ? 64'd1 : burst_flr;
			refill_ns = t;
			if (elapsed > GAP_CAP_NS)
				elapsed = GAP_CAP_NS;
			tokens = tokens + (elapsed * sess_rate) / SEC_NS;
			if (tokens > cap)
				tokens = cap;
			chunk = min64(chunk, cap);
			min_burst = min64(min64(remaining, floor_u), cap);
			if (tokens < min_burst) begin
				plan_wait = ((min_burst - tokens) * SEC_NS) / sess_rate;
				sess_phase = PH_WAIT;
				add_beat(K_WAIT, 64'd0, 64'd0, plan_wait);
				return;
			end
			chunk = min64(chunk, tokens);
			tokens = tokens - chunk;
		end
		plan_len = chunk;
		sess_phase = PH_BUSY;
		add_beat(K_SEND, (sess_start + sess_sent) & OFF_MASK, chunk, 64'd0);
	endfunction

	function automatic void pace_command(cmd_t c, logic [63:0] t, logic [47:0] rs,
			logic [47:0] re, logic [31:0] br, logic [24:0] nb);
		logic [63:0] span, cur;
		span = (hint_span < 64'd4) ? 64'd4 : hint_span;
		was_reject = 1'b0;
		if (c == CMD_START && sess_phase == PH_IDLE) begin
			sess_start = {16'b0, rs};
			sess_end = (re > rs) ? {16'b0, re} : {16'b0, rs};
			sess_total = sess_end - sess_start;
			sess_sent = 64'd0;
			sess_rate = {32'b0, br};
			tokens = sess_rate * 64'd2;
			refill_ns = t;
			hint_next = sat_add(sess_start, span);
			if (sess_total == 0) begin
				add_beat(K_FINISH, 64'd0, 64'd0, 64'd0);
			end else begin
				add_beat(K_HINT, sess_start, span, 64'd0);
				plan_chunk(t);
			end
		end else if (c == CMD_DONE && sess_phase == PH_BUSY) begin
			sess_sent = sess_sent + min64({39'b0, nb}, sess_total - sess_sent);
			cur = sess_start + sess_sent;
			if (cur >= hint_next - span / 64'd4 && hint_next < sess_end) begin
				add_beat(K_HINT, hint_next, span, 64'd0);
				hint_next = sat_add(hint_next, span);
			end
			if (sess_sent < sess_total) begin
				plan_chunk(t);
			end else begin
				sess_phase = PH_IDLE;
				add_beat(K_FINISH, 64'd0, 64'd0, 64'd0);
			end
		end else if (c == CMD_WAKE && sess_phase == PH_WAIT) begin
			plan_chunk(t);
		end else if (c == CMD_ERROR && sess_phase != PH_IDLE) begin
			sess_phase = PH_IDLE;
			add_beat(K_CANCEL, 64'd0, 64'd0, 64'd0);
		end else begin
			was_reject = 1'b1;
			add_beat(K_REJECT, 64'd0, 64'd0, 64'd0);
		end
		pending_beats[pending_beats.size()-1].last = 1'b1;
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			err_cnt++;
			if (err_cnt <= 10)
				$display("mismatch beat %0d %s: expected %0h got %0h", beat_no, name, want, got);
		end
	endfunction

	task automatic send_cmd(cmd_t c, logic [63:0] t, logic [47:0] rs, logic [47:0] re,
			logic [31:0] br, logic [24:0] nb);
		int gap;
		gap = 0;
		repeat (gap_left) @(posedge clk);
		gap_left = 0;
		in_valid <= 1'b1;
		cmd <= c;
		now_ns <= t[62:0];
		range_start <= rs;
		range_end <= re;
		byte_rate <= br;
		bytes_done <= nb;
		in_held = 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		pace_command(c, {1'b0, t[62:0]}, rs, re, br, nb);
		while ($urandom_range(99) < send_idle)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			in_held = 1'b0;
			gap_left = gap;
		end
	endtask

	task automatic drain();
		if (in_held) begin
			in_valid <= 1'b0;
			in_held = 1'b0;
		end
		gap_left = 0;
		while (pending_beats.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_regs(logic [31:0] cl, logic [31:0] bf, logic [31:0] ps);
		cfg_we <= 1'b1;
		cfg_index <= CFG_CHUNK_LIMIT;
		cfg_data <= cl;
		@(posedge clk);
		cfg_index <= CFG_BURST_FLOOR;
		cfg_data <= bf;
		@(posedge clk);
		cfg_index <= CFG_PREFETCH_SPAN;
		cfg_data <= ps;
		@(posedge clk);
		cfg_we <= 1'b0;
		chunk_lim = {39'b0, cl[24:0]};
		burst_flr = {39'b0, bf[24:0]};
		hint_span = {32'b0, ps};
	endtask

	// sessions with random content, plus stray and out-of-phase commands
	task automatic run_traffic(int n_items);
		int count, budget, r;
		logic [63:0] len, cu;
		logic [47:0] rs, re;
		logic [31:0] br;
		cmd_t c;
		count = 0;
		budget = 0;
		clock_ns = {$urandom, $urandom} >> 2;
		while (count < n_items) begin
			r = $urandom_range(99);
			if (sess_phase == PH_IDLE) begin
				budget = $urandom_range(4, 40);
				if (r < 8) begin
					send_cmd(cmd_t'($urandom_range(3)), {$urandom, $urandom}, rand48(), rand48(),
						$urandom, $urandom_range(DONE_MAX));
				end else begin
					cu = (chunk_lim == 0) ? 64'd1 : chunk_lim;
					len = cu * $urandom_range(1, 8) + $urandom_range(0, cu - 64'd1);
					rs = rand48();
					if (r < 13)
						len = 64'd0;
					else if (r < 20)
						rs = OFF_MASK[47:0] - len[47:0] - $urandom_range(64);
					re = rs + len[47:0];
					if (r >= 20 && r < 25)
						re = rs - $urandom_range(1, 5000);
					r = $urandom_range(99);
					if (r < 30)
						br = 32'd0;
					else if (r < 75)
						br = $urandom_range(100_000, 20_000_000);
					else if (r < 85)
						br = $urandom_range(1, 2000);
					else
						br = $urandom;
					clock_ns += $urandom_range(1_000_000);
					send_cmd(CMD_START, clock_ns, rs, re, br, $urandom_range(DONE_MAX));
				end
			end else if (budget <= 0 || r < 3) begin
				send_cmd(CMD_ERROR, clock_ns, rand48(), rand48(), $urandom,
					$urandom_range(DONE_MAX));
			end else if (r < 7) begin
				if (sess_phase == PH_BUSY)
					c = (r < 5) ? CMD_START : CMD_WAKE;
				else
					c = (r < 5) ? CMD_START : CMD_DONE;
				send_cmd(c, clock_ns, rand48(), rand48(), $urandom, $urandom_range(DONE_MAX));
			end else if (sess_phase == PH_BUSY) begin
				clock_ns += $urandom_range(20_000_000);
				if (r < 75)
					send_cmd(CMD_DONE, clock_ns, rand48(), rand48(), $urandom, plan_len[24:0]);
				else if (r < 85)
					send_cmd(CMD_DONE, clock_ns, rand48(), rand48(), $urandom,
						$urandom_range(0, plan_len));
				else if (r < 90)
					send_cmd(CMD_DONE, clock_ns, rand48(), rand48(), $urandom, 25'd0);
				else
					send_cmd(CMD_DONE, clock_ns, rand48(), rand48(), $urandom,
						$urandom_range(plan_len, DONE_MAX));
			end else begin
				if (r < 80) begin
					clock_ns += plan_wait + $urandom_range(1000);
					send_cmd(CMD_WAKE, clock_ns, rand48(), rand48(), $urandom,
						$urandom_range(DONE_MAX));
				end else if (r < 92) begin
					clock_ns += $urandom_range(0, plan_wait);
					send_cmd(CMD_WAKE, clock_ns, rand48(), rand48(), $urandom,
						$urandom_range(DONE_MAX));
				end else begin
					// clock seen running backward
					send_cmd(CMD_WAKE, clock_ns - $urandom_range(1, 1000), rand48(), rand48(),
						$urandom, $urandom_range(DONE_MAX));
				end
			end
			if (!was_reject)
				count++;
			budget--;
		end
	endtask

	task automatic test_directed();
		logic [47:0] top;
		top = '1;
		send_idle = 0;
		recv_stall = 0;
		clock_ns = 64'd1000;
		send_cmd(CMD_DONE, clock_ns, 48'd0, 48'd0, 32'd0, 25'd0);
		send_cmd(CMD_WAKE, clock_ns, 48'd0, 48'd0, 32'd0, 25'd0);
		send_cmd(CMD_ERROR, clock_ns, 48'd0, 48'd0, 32'd0, 25'd0);
		send_cmd(CMD_START, clock_ns, 48'd1000, 48'd1000, 32'd5, 25'd0);
		send_cmd(CMD_START, clock_ns, 48'd5000, 48'd10, 32'd0, 25'd0);
		send_cmd(CMD_START, clock_ns, 48'd0, 48'd3000, 32'd0, 25'd0);
		send_cmd(CMD_START, clock_ns, 48'd0, 48'd3000, 32'd0, 25'd0);
		send_cmd(CMD_WAKE, clock_ns, 48'd0, 48'd0, 32'd0, 25'd0);
		send_cmd(CMD_DONE, clock_ns, 48'd0, 48'd0, 32'd0, 25'd0);
		send_cmd(CMD_DONE, clock_ns, 48'd0, 48'd0, 32'd0, 25'd1000);
		send_cmd(CMD_DONE, clock_ns, 48'd0, 48'd0, 32'd0, 25'h1000000);
		// paced session: bucket drains, then waits
		clock_ns = 64'd50_000;
		send_cmd(CMD_START, clock_ns, 48'd7, 48'd100007, 32'd1000, 25'd0);
		send_cmd(CMD_DONE, clock_ns + 64'd1000, 48'd0, 48'd0, 32'd0, 25'd2000);
		send_cmd(CMD_DONE, clock_ns + 64'd2000, 48'd0, 48'd0, 32'd0, 25'd2000);
		send_cmd(CMD_WAKE, clock_ns - 64'd5, 48'd0, 48'd0, 32'd0, 25'd0);
		send_cmd(CMD_WAKE, clock_ns + 64'd10_000_000_000, 48'd0, 48'd0, 32'd0, 25'd0);
		send_cmd(CMD_ERROR, clock_ns, 48'd0, 48'd0, 32'd0, 25'd0);
		// hint watermark saturates at the top offset
		send_cmd(CMD_START, 64'h7FFF_FFFF_FFFF_FFFF, top - 48'd15, top, 32'd0, 25'd0);
		send_cmd(CMD_DONE, 64'h7FFF_FFFF_FFFF_FFFF, top, top, 32'd0, 25'd15);
		send_cmd(CMD_START, 64'h7FFF_FFFF_FFFF_FFFF, top, 48'd0, 32'hFFFF_FFFF, 25'h1000000);
		send_cmd(CMD_START, 64'd0, 48'd0, 48'd1 << 40, 32'hFFFF_FFFF, 25'd0);
		send_cmd(CMD_ERROR, 64'd0, top, top, 32'hFFFF_FFFF, 25'h1000000);
		drain();
	endtask

	task automatic test_small_chunks();
		set_regs(32'd4096, 32'd1024, 32'd16384);
		send_idle = 0;
		recv_stall = 0;
		run_traffic(275);
		drain();
	endtask

	task automatic test_sender_gaps();
		set_regs(32'd16777216, 32'd16777216, 32'hFFFF_FFFF);
		send_idle = 81;
		recv_stall = 0;
		run_traffic(275);
		drain();
	endtask

	task automatic test_receiver_stalls();
		set_regs(32'd0, 32'd0, 32'd0);
		send_idle = 0;
		recv_stall = 81;
		run_traffic(275);
		drain();
	endtask

	task automatic test_both_idle();
		set_regs(32'd1, 32'd1, 32'd3);
		send_idle = 24;
		recv_stall = 24;
		run_traffic(275);
		drain();
	endtask

	task automatic test_backpressure();
		set_regs(32'd65536, 32'd4096, 32'd1048576);
		send_idle = 0;
		recv_stall = 0;
		hold_left = 600;
		run_traffic(140);
		hold_left = 600;
		run_traffic(140);
		drain();
	endtask

	// receiver side
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_beats.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("unexpected beat %0d: kind %0d offset %0h length %0h", beat_no,
						kind, offset, length);
			end else begin
				want_beat = pending_beats.pop_front();
				check_field("kind", want_beat.kind, kind);
				check_field("offset", want_beat.offset, offset);
				check_field("length", want_beat.length, length);
				check_field("wait_ns", want_beat.wait_ns, wait_ns);
				check_field("last", want_beat.last, last);
			end
			beat_no++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_small_chunks();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_idle();
		test_backpressure();
		drain();
		repeat (200) @(posedge clk);
		if (err_cnt == 0 && pending_beats.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
